/* src/tpn_pkg.sv */
// ----------------------------------------------------------------------------
// tpn_pkg
// Shared types, character codes and helpers for the text prompt normalizer.
// ----------------------------------------------------------------------------
package tpn_pkg;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_EXCL  = 8'h21;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_NUL   = 8'h00;

	localparam logic [1:0] DOT_RUN_MAX = 2'd3;

	// result slots of one item, in emission order
	localparam int SLOT_SPACE  = 0;
	localparam int SLOT_BYTE   = 1;
	localparam int SLOT_MARKER = 2;
	localparam int NUM_SLOTS   = 3;

	typedef struct packed {
		logic       space_pending;
		logic       output_started;
		logic [7:0] prev_char;
		logic [1:0] dot_run;
	} tpn_state_t;

	typedef struct packed {
		logic [NUM_SLOTS-1:0] valid;
		logic [7:0]           byte_val;
	} tpn_slots_t;

	localparam tpn_state_t STATE_RESET = '{
		space_pending:  1'b0,
		output_started: 1'b0,
		prev_char:      CH_NUL,
		dot_run:        2'd0
	};

	function automatic logic is_punct(input logic [7:0] c);
		return (c == CH_COMMA) || (c == CH_DOT) || (c == CH_QMARK) ||
		       (c == CH_EXCL) || (c == CH_COLON) || (c == CH_SEMI);
	endfunction

endpackage

/* src/tpn_decode.sv */
// ----------------------------------------------------------------------------
// tpn_decode
// Classifies one byte against the current state: which result slots it
// fills and the state left once all of its results are out.
// ----------------------------------------------------------------------------
module tpn_decode (
	input  logic [7:0]          in_byte,
	input  logic                end_of_text,
	input  tpn_pkg::tpn_state_t cur,
	output tpn_pkg::tpn_slots_t slots,
	output tpn_pkg::tpn_state_t nxt
);

	logic drop_ctl;
	logic is_space;
	logic is_pun;
	logic dup_drop;
	logic emit_byte;
	logic emit_space;

	always_comb begin
		drop_ctl = (in_byte < tpn_pkg::CH_SPACE) || (in_byte == tpn_pkg::CH_DEL) ||
		           (in_byte == tpn_pkg::CH_QUOTE);
		is_space = (in_byte == tpn_pkg::CH_SPACE);
		is_pun   = tpn_pkg::is_punct(in_byte);
		dup_drop = (((in_byte == tpn_pkg::CH_QMARK) || (in_byte == tpn_pkg::CH_EXCL)) &&
		            cur.output_started && (cur.prev_char == in_byte)) ||
		           ((in_byte == tpn_pkg::CH_DOT) && (cur.dot_run == tpn_pkg::DOT_RUN_MAX));

		emit_byte  = 1'b0;
		emit_space = 1'b0;
		nxt        = cur;

		if (drop_ctl) begin
			// drop
		end else if (is_space) begin
			nxt.space_pending = cur.output_started;
		end else if (is_pun) begin
			emit_byte         = !dup_drop;
			nxt.space_pending = 1'b1;
		end else begin
			emit_space        = cur.space_pending && cur.output_started;
			emit_byte         = 1'b1;
			nxt.space_pending = 1'b0;
		end

		// the byte is the last emitted either way, so it alone sets history
		if (emit_byte) begin
			nxt.output_started = 1'b1;
			nxt.prev_char      = in_byte;
			if (in_byte == tpn_pkg::CH_DOT) begin
				if (cur.dot_run != tpn_pkg::DOT_RUN_MAX) begin
					nxt.dot_run = cur.dot_run + 2'd1;
				end
			end else begin
				nxt.dot_run = 2'd0;
			end
		end

		if (end_of_text) begin
			nxt = tpn_pkg::STATE_RESET;
		end

		slots.valid[tpn_pkg::SLOT_SPACE]  = emit_space;
		slots.valid[tpn_pkg::SLOT_BYTE]   = emit_byte;
		slots.valid[tpn_pkg::SLOT_MARKER] = end_of_text;
		slots.byte_val                    = in_byte;
	end

endmodule

/* src/text_prompt_normalizer_top.sv */
// ----------------------------------------------------------------------------
// text_prompt_normalizer_top
// Streaming text normalizer: filters raw text bytes into normalized bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one raw byte per item in s_tdata, s_tlast marks the
//   final byte of a text. Master channel m_*: one result per item; m_tdata
//   is the output byte, m_tuser flags the end-of-text marker (byte zero),
//   m_tlast marks the final result caused by one input byte.
//   An accepted byte sits in an input register; each cycle the output
//   register is free, the next of its up to three results (deferred space,
//   byte, marker) moves into the output register. Plain text runs at one
//   byte per cycle while the receiver keeps up; a byte with a deferred space
//   or at end of text holds the input until its results are out. Normalizer
//   state (pending space, last byte, dot run) updates when the byte's last
//   result is loaded, or when the byte has no results at all.
//   When the receiver stalls, the output register holds and the input
//   register fills; s_tready drops once both are occupied.
//   Reset clears all valid flags and the normalizer state.
// ----------------------------------------------------------------------------
module text_prompt_normalizer_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,   // end_of_text
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tuser,   // end_mark
	output logic       m_tlast    // last_of_run
);

	localparam int NS = tpn_pkg::NUM_SLOTS;

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                eot_s1;
	logic [NS-1:0]       sent_q;
	tpn_pkg::tpn_state_t state_q;

	tpn_pkg::tpn_slots_t slots;
	tpn_pkg::tpn_state_t state_nxt;

	logic [NS-1:0] remaining;
	logic [NS-1:0] pick;
	logic          pick_last;
	logic          out_free;
	logic          load_out;
	logic          done_s1;
	logic          accept_in;

	logic       m_valid_q;
	logic [7:0] m_data_q;
	logic       m_user_q;
	logic       m_last_q;

	tpn_decode u_decode (
		.in_byte     (byte_s1),
		.end_of_text (eot_s1),
		.cur         (state_q),
		.slots       (slots),
		.nxt         (state_nxt)
	);

	always_comb begin
		remaining = valid_s1 ? (slots.valid & ~sent_q) : '0;
		pick      = remaining & (~remaining + NS'(1));
		pick_last = ((remaining & ~pick) == '0);
		out_free  = !m_valid_q || m_tready;
		load_out  = out_free && (remaining != '0);
		// an item with nothing left to send retires without the output side
		done_s1   = valid_s1 && ((remaining == '0) || (load_out && pick_last));
		s_tready  = !valid_s1 || done_s1;
		accept_in = s_tvalid && s_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			sent_q   <= '0;
			state_q  <= tpn_pkg::STATE_RESET;
		end else begin
			if (done_s1) begin
				state_q <= state_nxt;
			end
			if (accept_in) begin
				valid_s1 <= 1'b1;
				sent_q   <= '0;
			end else if (done_s1) begin
				valid_s1 <= 1'b0;
				sent_q   <= '0;
			end else if (load_out) begin
				sent_q <= sent_q | pick;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			byte_s1 <= s_tdata;
			eot_s1  <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= load_out;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_last_q <= pick_last;
			m_user_q <= pick[tpn_pkg::SLOT_MARKER];
			if (pick[tpn_pkg::SLOT_SPACE]) begin
				m_data_q <= tpn_pkg::CH_SPACE;
			end else if (pick[tpn_pkg::SLOT_BYTE]) begin
				m_data_q <= slots.byte_val;
			end else begin
				m_data_q <= tpn_pkg::CH_NUL;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;
	assign m_tlast  = m_last_q;

	// the end marker is always the final result of its byte and carries zero
	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == tpn_pkg::CH_NUL)))
		else $error("end marker not last or nonzero");

	// an empty input register never blocks the slave side
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("s_tready low with empty input register");

	// a fresh item starts with no slot sent
	a_fresh_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept_in |=> (valid_s1 && (sent_q == '0)))
		else $error("accepted item not loaded cleanly");

	// the output register only changes when it was free
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
		else $error("stalled result changed");

endmodule
